[sv/dma_buffer_grant_tracker_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef DMA_BUFFER_GRANT_TRACKER_TOP_DEFINES_SVH
`define DMA_BUFFER_GRANT_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DBGT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbgt check failed: label");

// Next-cycle implication, ignored while reset is asserted.
`define DBGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbgt check failed: label");

// Next-cycle implication that is also checked during reset.
`define DBGT_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dbgt check failed: label");

`endif

[sv/dbgt_pkg.sv]
`default_nettype none
package dbgt_pkg;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_BORROW_SOURCE = 3'd0,
    CMD_BORROW_LOCAL  = 3'd1,
    CMD_RELEASE       = 3'd2,
    CMD_DROP_IF_FROM  = 3'd3,
    CMD_MAP           = 3'd4,
    CMD_SYNC          = 3'd5,
    CMD_UNMAP         = 3'd6,
    CMD_CLEAR         = 3'd7
  } cmd_t;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // One command transfer.
  typedef struct packed {
    cmd_t        command;
    logic [31:0] context_id;
    logic [7:0]  request_flags;
    logic [7:0]  allowed_mask;
    logic [31:0] buffer_bytes;
    logic [31:0] window_offset;
    logic [31:0] window_length;
    logic [31:0] direction_bits;
  } req_t;

  // One result transfer.
  typedef struct packed {
    logic        status;
    logic        borrowed;
    logic        mapped;
    logic [31:0] owner_context;
    logic [7:0]  held_flags;
    logic [31:0] mapped_offset;
    logic [31:0] mapped_length;
    logic [31:0] mapped_direction;
  } res_t;

  // Handshake between the input register and the result register.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

[sv/dbgt_if.sv]
`default_nettype none
// Command channel.
interface dbgt_in_if import dbgt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface dbgt_out_if import dbgt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/dbgt_in_stage.sv]
`default_nettype none
module dbgt_in_stage import dbgt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dbgt_in_if.sink   in_ch,
  input  wire logic s1_ready,
  output logic      s1_valid,
  output req_t      s1_req
);

  logic vld_r;
  logic vld_nxt;
  req_t req_r;

  // The register takes a new transfer when empty or when its item moves on.
  assign in_ch.ready = !vld_r || s1_ready;
  assign vld_nxt     = in_ch.valid || (vld_r && !s1_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.data;
    end
  end

  assign s1_valid = vld_r;
  assign s1_req   = req_r;

endmodule
`default_nettype wire

[sv/dbgt_core.sv]
`default_nettype none
module dbgt_core import dbgt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire hs_t  s1_hs,
  input  wire req_t s1_req,
  output res_t      res
);

  logic        borrow_on_r, borrow_on_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] owner_r, owner_nxt;
  logic        map_on_r, map_on_nxt;
  logic [31:0] dir_r, dir_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] size_r, size_nxt;

  logic        ok;
  logic        flags_ok;
  logic        owner_match;
  logic [32:0] win_sum;
  logic        map_fits;
  logic        sync_fits;
  logic        fire;

  assign fire = s1_hs.valid && s1_hs.ready;

  // Shared checks: flag subset, owner compare and the 33-bit window end.
  assign flags_ok    = (s1_req.request_flags != 8'd0) && (s1_req.allowed_mask != 8'd0) &&
                       ((s1_req.request_flags & s1_req.allowed_mask) == s1_req.request_flags);
  assign owner_match = (owner_r == s1_req.context_id);
  assign win_sum     = {1'b0, s1_req.window_offset} + {1'b0, s1_req.window_length};
  assign map_fits    = (s1_req.window_offset < s1_req.buffer_bytes) &&
                       (s1_req.window_length <= s1_req.buffer_bytes) &&
                       (win_sum <= {1'b0, s1_req.buffer_bytes});
  assign sync_fits   = (s1_req.window_offset <= size_r) &&
                       (s1_req.window_length <= size_r) &&
                       (win_sum <= {1'b0, size_r});

  // Command decode and next state.
  always_comb begin
    borrow_on_nxt = borrow_on_r;
    flags_nxt     = flags_r;
    owner_nxt     = owner_r;
    map_on_nxt    = map_on_r;
    dir_nxt       = dir_r;
    start_nxt     = start_r;
    size_nxt      = size_r;
    ok            = 1'b0;
    case (s1_req.command)
      CMD_BORROW_SOURCE, CMD_BORROW_LOCAL: begin
        if ((s1_req.command == CMD_BORROW_LOCAL || s1_req.context_id != 32'd0) &&
            flags_ok && !borrow_on_r && !map_on_r) begin
          borrow_on_nxt = 1'b1;
          flags_nxt     = s1_req.request_flags;
          owner_nxt     = (s1_req.command == CMD_BORROW_LOCAL) ? 32'd0 : s1_req.context_id;
          map_on_nxt    = 1'b0;
          dir_nxt       = 32'd0;
          start_nxt     = 32'd0;
          size_nxt      = 32'd0;
          ok            = 1'b1;
        end
      end
      CMD_RELEASE, CMD_DROP_IF_FROM: begin
        // Release needs an unmapped borrow; a drop needs a nonzero matching owner and always passes.
        if ((s1_req.command == CMD_RELEASE) ? (borrow_on_r && !map_on_r) :
            (s1_req.context_id != 32'd0 && borrow_on_r && owner_match)) begin
          borrow_on_nxt = 1'b0;
          flags_nxt     = 8'd0;
          owner_nxt     = 32'd0;
          map_on_nxt    = 1'b0;
          dir_nxt       = 32'd0;
          start_nxt     = 32'd0;
          size_nxt      = 32'd0;
          ok            = 1'b1;
        end
        if (s1_req.command == CMD_DROP_IF_FROM) begin
          ok = 1'b1;
        end
      end
      CMD_MAP: begin
        if (borrow_on_r && !map_on_r && s1_req.direction_bits != 32'd0 &&
            s1_req.window_length != 32'd0 && owner_match && map_fits) begin
          map_on_nxt = 1'b1;
          dir_nxt    = s1_req.direction_bits;
          start_nxt  = s1_req.window_offset;
          size_nxt   = s1_req.window_length;
          ok         = 1'b1;
        end
      end
      CMD_SYNC: begin
        ok = map_on_r && (s1_req.window_length != 32'd0) && sync_fits;
      end
      CMD_UNMAP: begin
        if (borrow_on_r && map_on_r && owner_match) begin
          map_on_nxt = 1'b0;
          dir_nxt    = 32'd0;
          start_nxt  = 32'd0;
          size_nxt   = 32'd0;
          ok         = 1'b1;
        end
      end
      default: begin
        // Clear returns everything to zero.
        borrow_on_nxt = 1'b0;
        flags_nxt     = 8'd0;
        owner_nxt     = 32'd0;
        map_on_nxt    = 1'b0;
        dir_nxt       = 32'd0;
        start_nxt     = 32'd0;
        size_nxt      = 32'd0;
        ok            = 1'b1;
      end
    endcase
  end

  // Buffer state, updated once per command transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      borrow_on_r <= 1'b0;
      flags_r     <= 8'd0;
      owner_r     <= 32'd0;
      map_on_r    <= 1'b0;
      dir_r       <= 32'd0;
      start_r     <= 32'd0;
      size_r      <= 32'd0;
    end else if (fire) begin
      borrow_on_r <= borrow_on_nxt;
      flags_r     <= flags_nxt;
      owner_r     <= owner_nxt;
      map_on_r    <= map_on_nxt;
      dir_r       <= dir_nxt;
      start_r     <= start_nxt;
      size_r      <= size_nxt;
    end
  end

  // The result reports the state after the command.
  always_comb begin
    res.status           = ok ? STATUS_OK : STATUS_REJECTED;
    res.borrowed         = borrow_on_nxt;
    res.mapped           = map_on_nxt;
    res.owner_context    = owner_nxt;
    res.held_flags       = flags_nxt;
    res.mapped_offset    = start_nxt;
    res.mapped_length    = size_nxt;
    res.mapped_direction = dir_nxt;
  end

endmodule
`default_nettype wire

[sv/dbgt_out_stage.sv]
`default_nettype none
module dbgt_out_stage import dbgt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s1_valid,
  input  wire res_t res,
  output logic      s1_ready,
  dbgt_out_if.source out_ch
);

  logic vld_r;
  res_t res_r;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign s1_ready = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (s1_ready) begin
      vld_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = vld_r;
  assign out_ch.data  = res_r;

endmodule
`default_nettype wire

[sv/dma_buffer_grant_tracker_top.sv]
// Ownership and DMA-window tracker for one buffer. Every command transfer on
// in_ch yields exactly one result transfer on out_ch, in order, carrying the
// accept/reject status and the full buffer state after the command. A new
// command is taken every cycle unless back-pressure stalls it: each passes
// the command register, then the result register, and the rate of one command
// per cycle is set by the single update of the state registers in the decode
// stage, which reads the state left by the previous command. Back-pressure on
// out_ch stalls the command register only once the result register is full.
`default_nettype none
module dma_buffer_grant_tracker_top import dbgt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dbgt_in_if.sink    in_ch,
  dbgt_out_if.source out_ch
);

  hs_t  s1_hs;
  req_t s1_req;
  res_t res;
  logic s1_valid;
  logic s1_ready;

  assign s1_hs.valid = s1_valid;
  assign s1_hs.ready = s1_ready;

  // Command register.
  dbgt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  // Decode and buffer state.
  dbgt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_hs  (s1_hs),
    .s1_req (s1_req),
    .res    (res)
  );

  // Result register.
  dbgt_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .res      (res),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

[sv/dbgt_checker.sv]
`default_nettype none
`include "dma_buffer_grant_tracker_top_defines.svh"
module dbgt_checker import dbgt_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire res_t out_data
);

  // A stalled result holds.
  `DBGT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // No result is offered in the cycle after reset.
  `DBGT_ASSERT_NEXT_RST(a_rst_empty, !rst_n, !out_valid)

  // A mapping only exists under an active borrow.
  `DBGT_ASSERT_IMP(a_map_needs_borrow, out_valid && out_data.mapped, out_data.borrowed)

  // Without a borrow, owner and flags read as zero.
  `DBGT_ASSERT_IMP(a_idle_borrow_zero, out_valid && !out_data.borrowed,
                   out_data.owner_context == 32'd0 && out_data.held_flags == 8'd0)

  // Without a mapping, the window reads as zero.
  `DBGT_ASSERT_IMP(a_idle_window_zero, out_valid && !out_data.mapped,
                   out_data.mapped_offset == 32'd0 && out_data.mapped_length == 32'd0 &&
                   out_data.mapped_direction == 32'd0)

endmodule

bind dma_buffer_grant_tracker_top dbgt_checker u_dbgt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

[tb/dbgt_state_checker.sv]
module dbgt_state_checker import dbgt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dbgt_in_if   in_ch,
  dbgt_out_if  out_ch,
  output int   mismatch_count,
  output int   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the buffer ownership and DMA window.
  logic        grant_held;
  logic [7:0]  held_bits;
  logic [31:0] owner;
  logic        window_active;
  logic [31:0] window_dir;
  logic [31:0] window_start;
  logic [31:0] window_len;

  // Expected result for every command transfer not yet answered, oldest first.
  res_t expected_results[$];

  // A window fits when it starts inside the limit and its end, taken at 33 bits,
  // does not pass the limit. Map needs the start strictly below the limit.
  function automatic logic window_fits(input logic [31:0] off, input logic [31:0] len,
                                       input logic [31:0] lim, input logic strict_start);
    logic [32:0] span_end;
    span_end = {1'b0, off} + {1'b0, len};
    if (strict_start ? (off >= lim) : (off > lim)) return 1'b0;
    if (len > lim) return 1'b0;
    return span_end <= {1'b0, lim};
  endfunction

  function automatic void drop_window();
    window_active = 1'b0;
    window_dir    = '0;
    window_start  = '0;
    window_len    = '0;
  endfunction

  function automatic void drop_everything();
    grant_held = 1'b0;
    held_bits  = '0;
    owner      = '0;
    drop_window();
  endfunction

  // Applies one command to the shadow state and returns the result it must produce.
  function automatic res_t apply_command(input req_t c);
    logic accepted;
    res_t r;
    accepted = 1'b0;
    case (c.command)
      CMD_BORROW_SOURCE, CMD_BORROW_LOCAL: begin
        if ((c.command == CMD_BORROW_LOCAL || c.context_id != '0) &&
            c.request_flags != '0 && c.allowed_mask != '0 &&
            (c.request_flags & ~c.allowed_mask) == '0 &&
            !grant_held && !window_active) begin
          grant_held = 1'b1;
          held_bits  = c.request_flags;
          owner      = (c.command == CMD_BORROW_LOCAL) ? '0 : c.context_id;
          drop_window();
          accepted = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (grant_held && !window_active) begin
          drop_everything();
          accepted = 1'b1;
        end
      end
      CMD_DROP_IF_FROM: begin
        if (c.context_id != '0 && grant_held && owner == c.context_id) drop_everything();
        accepted = 1'b1;
      end
      CMD_MAP: begin
        if (grant_held && !window_active && c.direction_bits != '0 &&
            c.window_length != '0 && owner == c.context_id &&
            window_fits(c.window_offset, c.window_length, c.buffer_bytes, 1'b1)) begin
          window_active = 1'b1;
          window_dir    = c.direction_bits;
          window_start  = c.window_offset;
          window_len    = c.window_length;
          accepted = 1'b1;
        end
      end
      CMD_SYNC: begin
        accepted = window_active && c.window_length != '0 &&
                   window_fits(c.window_offset, c.window_length, window_len, 1'b0);
      end
      CMD_UNMAP: begin
        if (grant_held && window_active && owner == c.context_id) begin
          drop_window();
          accepted = 1'b1;
        end
      end
      default: begin
        // Clear returns everything to zero.
        drop_everything();
        accepted = 1'b1;
      end
    endcase
    r.status           = accepted ? STATUS_OK : STATUS_REJECTED;
    r.borrowed         = grant_held;
    r.mapped           = window_active;
    r.owner_context    = owner;
    r.held_flags       = held_bits;
    r.mapped_offset    = window_start;
    r.mapped_length    = window_len;
    r.mapped_direction = window_dir;
    return r;
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("status=%b borrowed=%b mapped=%b owner=%h flags=%h off=%h len=%h dir=%h",
                     r.status, r.borrowed, r.mapped, r.owner_context, r.held_flags,
                     r.mapped_offset, r.mapped_length, r.mapped_direction);
  endfunction

  // Both channels are sampled at the rising edge; the result side is handled
  // first since it always answers an older command.
  always @(posedge clk) begin : watch
    res_t  got;
    res_t  want;
    string bad;
    if (!rst_n) begin
      drop_everything();
      expected_results.delete();
      results_pending = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result transfer with no command outstanding: %s",
                     $time, describe(got));
        end else begin
          want = expected_results.pop_front();
          bad  = "";
          if (got.status !== want.status) bad = {bad, " status"};
          if (got.borrowed !== want.borrowed) bad = {bad, " borrowed"};
          if (got.mapped !== want.mapped) bad = {bad, " mapped"};
          if (got.owner_context !== want.owner_context) bad = {bad, " owner_context"};
          if (got.held_flags !== want.held_flags) bad = {bad, " held_flags"};
          if (got.mapped_offset !== want.mapped_offset) bad = {bad, " mapped_offset"};
          if (got.mapped_length !== want.mapped_length) bad = {bad, " mapped_length"};
          if (got.mapped_direction !== want.mapped_direction) bad = {bad, " mapped_direction"};
          if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("[%0t] result mismatch in%s", $time, bad);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expected_results.push_back(apply_command(in_ch.data));
      results_pending = expected_results.size();
    end
  end

endmodule

[tb/tb_dma_buffer_grant_tracker_top.sv]
module tb_dma_buffer_grant_tracker_top import dbgt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 6;
  localparam int TOTAL_ITEMS  = 575;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n;

  dbgt_in_if  in_ch ();
  dbgt_out_if out_ch ();

  int mismatch_count;
  int results_pending;
  int items_sent = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int cycle_count = 0;

  dma_buffer_grant_tracker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dbgt_state_checker grant_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t make_cmd(input cmd_t op, input logic [31:0] ctx,
                                    input logic [7:0] req, input logic [7:0] allow,
                                    input logic [31:0] buf_size, input logic [31:0] off,
                                    input logic [31:0] len, input logic [31:0] dir);
    req_t c;
    c.command        = op;
    c.context_id     = ctx;
    c.request_flags  = req;
    c.allowed_mask   = allow;
    c.buffer_bytes   = buf_size;
    c.window_offset  = off;
    c.window_length  = len;
    c.direction_bits = dir;
    return c;
  endfunction

  // Offers one command and waits for its transfer. Bursts of random length are
  // followed by a random gap with valid low.
  task automatic send_command(input req_t c);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Stops offering commands until every result has come back.
  task automatic drain_results();
    @(negedge clk) in_ch.valid <= 1'b0;
    wait (results_pending == 0);
  endtask

  task automatic send_noise();
    send_command(make_cmd(cmd_t'($urandom_range(0, 7)), $urandom, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), $urandom, $urandom, $urandom,
                          $urandom));
  endtask

  // One ownership session: a borrow, a few map / sync / unmap rounds that are
  // mostly well formed, then a teardown. Some steps are broken on purpose.
  task automatic send_grant_session();
    logic        local_grant;
    logic [31:0] ctx;
    logic [31:0] map_ctx;
    logic [31:0] buf_size;
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] dir;
    logic [31:0] sub_off;
    logic [31:0] sub_len;
    logic [7:0]  req;
    logic [7:0]  allow;
    int          rounds;
    local_grant = ($urandom_range(0, 3) == 0);
    ctx = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 15);
    req = 8'($urandom_range(1, 255));
    allow = req | 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) allow = 8'($urandom_range(0, 255));
    send_command(make_cmd(local_grant ? CMD_BORROW_LOCAL : CMD_BORROW_SOURCE,
                          local_grant ? $urandom : ctx, req, allow,
                          $urandom, $urandom, $urandom, $urandom));
    if (local_grant) ctx = '0;

    rounds = $urandom_range(1, 4);
    repeat (rounds) begin
      buf_size = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 4096);
      if (buf_size == '0) buf_size = 32'd1;
      off = $urandom_range(0, buf_size - 1);
      len = $urandom_range(1, buf_size - off);
      dir = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom;
      map_ctx = ctx;
      // Occasionally break one of the map checks.
      case ($urandom_range(0, 11))
        0: off = buf_size;
        1: len = buf_size - off + 32'd1;
        2: len = '0;
        3: dir = '0;
        4: map_ctx = ctx ^ (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
      send_command(make_cmd(CMD_MAP, map_ctx, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), buf_size, off, len, dir));

      repeat ($urandom_range(0, 4)) begin
        sub_off = $urandom_range(0, len);
        sub_len = $urandom_range(1, (len == sub_off) ? 1 : len - sub_off);
        if ($urandom_range(0, 5) == 0) sub_len = $urandom;
        if ($urandom_range(0, 9) == 0) sub_off = $urandom;
        send_command(make_cmd(CMD_SYNC, $urandom, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), $urandom, sub_off, sub_len,
                              $urandom));
      end
      if ($urandom_range(0, 7) == 0) send_noise();

      // Unmap, now and then from the wrong context or not at all.
      if ($urandom_range(0, 9) != 0)
        send_command(make_cmd(CMD_UNMAP, ($urandom_range(0, 7) == 0) ? ctx + 32'd1 : ctx,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              $urandom, $urandom, $urandom, $urandom));
    end

    // Teardown of the borrow.
    case ($urandom_range(0, 3))
      0, 1: send_command(make_cmd(CMD_RELEASE, $urandom, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), $urandom, $urandom, $urandom,
                                  $urandom));
      2: send_command(make_cmd(CMD_DROP_IF_FROM, ctx, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), $urandom, $urandom, $urandom,
                               $urandom));
      default: send_command(make_cmd(CMD_CLEAR, $urandom, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), $urandom, $urandom,
                                     $urandom, $urandom));
    endcase
  endtask

  // Result side: stretches of different acceptance rates, plus a long hold-off
  // whenever one is requested.
  initial begin : result_sink
    int hold_served;
    int accept_pct;
    int span;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: accept_pct = 100;
        1: accept_pct = 70;
        2: accept_pct = 35;
        default: accept_pct = 10;
      endcase
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_requests != hold_served) begin
          hold_served = hold_requests;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        out_ch.ready <= ($urandom_range(1, 100) <= accept_pct);
      end
    end
  end

  // Command side: reset, directed cases, then random sessions and noise.
  initial begin
    int pick;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Borrows that fail the context or flag checks on an idle buffer.
    send_command(make_cmd(CMD_BORROW_SOURCE, 32'h0, 8'h01, 8'h01, 0, 0, 0, 0));
    send_command(make_cmd(CMD_BORROW_SOURCE, 32'h1, 8'h00, 8'hFF, 0, 0, 0, 0));
    send_command(make_cmd(CMD_BORROW_LOCAL, 32'h0, 8'h01, 8'h00, 0, 0, 0, 0));
    send_command(make_cmd(CMD_BORROW_SOURCE, 32'h5, 8'h81, 8'h80, 0, 0, 0, 0));
    // Commands that need an active borrow or map.
    send_command(make_cmd(CMD_RELEASE, 32'h0, 8'h0, 8'h0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_MAP, 32'h0, 8'h0, 8'h0, 32'd16, 32'd0, 32'd4, 32'd1));
    send_command(make_cmd(CMD_SYNC, 32'h0, 8'h0, 8'h0, 0, 32'd0, 32'd1, 0));
    send_command(make_cmd(CMD_UNMAP, 32'h0, 8'h0, 8'h0, 0, 0, 0, 0));
    // Borrow with every flag, then a second borrow while busy.
    send_command(make_cmd(CMD_BORROW_SOURCE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0, 0, 0, 0));
    send_command(make_cmd(CMD_BORROW_LOCAL, 32'h0, 8'h01, 8'h01, 0, 0, 0, 0));
    // Map rejections: wrong owner, no direction, empty window, start at the end,
    // window longer than the buffer, and an end that wraps at 32 bits.
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFE, 8'h0, 8'h0, 32'd100, 32'd0, 32'd10, 32'd1));
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'd100, 32'd0, 32'd10, 32'd0));
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'd100, 32'd0, 32'd0, 32'd1));
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'd100, 32'd100, 32'd1, 32'd1));
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'd10, 32'd0, 32'd11, 32'd1));
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                          32'd2, 32'd1));
    // A window that ends exactly at the largest buffer.
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'hFFFF_FFFF, 32'd1,
                          32'hFFFF_FFFE, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_RELEASE, 32'h0, 8'h0, 8'h0, 0, 0, 0, 0));
    // Sync: wrapping end, empty range, and the full mapped length.
    send_command(make_cmd(CMD_SYNC, 32'h0, 8'h0, 8'h0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_command(make_cmd(CMD_SYNC, 32'h0, 8'h0, 8'h0, 0, 32'd0, 32'd0, 0));
    send_command(make_cmd(CMD_SYNC, 32'h0, 8'h0, 8'h0, 0, 32'd0, 32'hFFFF_FFFE, 0));
    // Drops that do not match leave everything in place.
    send_command(make_cmd(CMD_DROP_IF_FROM, 32'h0, 8'h0, 8'h0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_DROP_IF_FROM, 32'h1, 8'h0, 8'h0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_UNMAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 0, 0, 0, 0));
    // A matching drop also tears down an active map.
    send_command(make_cmd(CMD_MAP, 32'hFFFF_FFFF, 8'h0, 8'h0, 32'd64, 32'd63, 32'd1, 32'd2));
    send_command(make_cmd(CMD_DROP_IF_FROM, 32'hFFFF_FFFF, 8'h0, 8'h0, 0, 0, 0, 0));
    // Local borrow ignores the context and owns as zero.
    send_command(make_cmd(CMD_BORROW_LOCAL, 32'hDEAD_BEEF, 8'h01, 8'h03, 0, 0, 0, 0));
    send_command(make_cmd(CMD_CLEAR, 32'h0, 8'h0, 8'h0, 0, 0, 0, 0));
    drain_results();

    // Receiver holds off while sessions keep coming, so the input stalls.
    hold_requests++;
    burst_left = 40;
    repeat (3) send_grant_session();
    drain_results();

    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        hold_requests++;
        burst_left = 40;
      end else if (pick == 1) begin
        drain_results();
      end
      if (pick < 16) send_grant_session();
      else send_noise();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
